// File: sv/sdd_pkg.sv
// Shared types and constants for the string duplicate detector.
// Used by sdd_front, sdd_back, string_duplicate_detector and the testbench; depends on nothing.
`default_nettype none
package sdd_pkg;

  localparam int HASH_W   = 32;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 12;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2047;

  localparam logic [STATUS_W-1:0] ST_NEW    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SECOND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPEAT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LONG   = 3'd4;

  // A completed name handed from the front end to the probe engine.
  typedef struct packed {
    logic              valid;
    logic              overflow;
    logic [HASH_W-1:0] hash;
  } job_ctl_t;

endpackage
`default_nettype wire

// File: sv/sdd_front.sv
// Front end: accepts characters, builds the shift-add hash and buffers the name.
// Depends on sdd_pkg; feeds sdd_back through a one-entry job slot.
`default_nettype none
module sdd_front #(
  parameter int MAX_NAME_CHARS = 40,
  parameter int LW = 6,
  parameter int NW = 6
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [sdd_pkg::CHAR_W-1:0]   in_tdata,
  input  wire                          in_tlast,
  input  wire                          clr_busy,
  input  wire                          job_done,
  output sdd_pkg::job_ctl_t            job,
  output logic [LW-1:0]                job_len,
  input  wire  [NW-1:0]                buf_rd_addr,
  output logic [sdd_pkg::CHAR_W-1:0]   buf_rd_data
);

  logic [sdd_pkg::HASH_W-1:0] hash_r, hash_nxt;
  logic [LW-1:0]              len_r;
  logic                       ovf_r;
  logic                       job_valid_r;
  logic                       accept;
  logic                       room;
  logic [sdd_pkg::CHAR_W-1:0] name_mem [MAX_NAME_CHARS];

  assign in_tready = !job_valid_r && !clr_busy;
  assign accept    = in_tvalid && in_tready;
  assign room      = len_r < LW'(MAX_NAME_CHARS);
  assign hash_nxt  = {hash_r[sdd_pkg::HASH_W-6:0], 5'b0} +
                     {{(sdd_pkg::HASH_W-sdd_pkg::CHAR_W){1'b0}}, in_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      job_valid_r <= 1'b0;
    end else if (job_done) begin
      hash_r      <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      job_valid_r <= 1'b0;
    end else if (accept) begin
      hash_r <= hash_nxt;
      if (room) begin
        len_r <= len_r + LW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
      job_valid_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      name_mem[len_r[NW-1:0]] <= in_tdata;
    end
    buf_rd_data <= name_mem[buf_rd_addr];
  end

  assign job.valid    = job_valid_r;
  assign job.overflow = ovf_r;
  assign job.hash     = hash_r;
  assign job_len      = len_r;

endmodule
`default_nettype wire

// File: sv/sdd_back.sv
// Back end: modulo reduction, quadratic probing, name compare and store, result register.
// Depends on sdd_pkg; reads the name buffer held in sdd_front.
`default_nettype none
module sdd_back #(
  parameter int TABLE_SLOTS    = 4093,
  parameter int MAX_NAME_CHARS = 40,
  parameter int SW  = 12,
  parameter int LW  = 6,
  parameter int NW  = 6,
  parameter int CAW = 18
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  sdd_pkg::job_ctl_t             job,
  input  wire  [LW-1:0]                 job_len,
  input  wire  [sdd_pkg::LIMIT_W-1:0]   probe_limit,
  output logic [NW-1:0]                 buf_rd_addr,
  input  wire  [sdd_pkg::CHAR_W-1:0]    buf_rd_data,
  output logic                          job_done,
  output logic                          clr_busy,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [sdd_pkg::STATUS_W-1:0]  out_status,
  output logic [SW-1:0]                 out_slot
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_CMPA = 4'd5;
  localparam logic [3:0] S_CMPB = 4'd6;
  localparam logic [3:0] S_CPA  = 4'd7;
  localparam logic [3:0] S_CPB  = 4'd8;
  localparam logic [3:0] S_NEXT = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic [SW:0] NMOD = (SW+1)'(TABLE_SLOTS);
  // Weight of one unit above the low SW bits, reduced modulo the table size.
  localparam logic [sdd_pkg::HASH_W-1:0] FOLD_K =
    sdd_pkg::HASH_W'((1 << SW) % TABLE_SLOTS);

  logic [3:0]                     state_r, state_nxt;
  logic [SW-1:0]                  clr_r, clr_nxt;
  logic [sdd_pkg::HASH_W-1:0]     fold_r, fold_nxt;
  logic [SW-1:0]                  p_r, p_nxt;
  logic [SW-1:0]                  inc_r, inc_nxt;
  logic [sdd_pkg::LIMIT_W-1:0]    step_r, step_nxt;
  logic [CAW-1:0]                 base_r, base_nxt;
  logic [LW-1:0]                  idx_r, idx_nxt;
  logic [sdd_pkg::STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic [SW-1:0]                  res_slot_r, res_slot_nxt;
  logic                           out_valid_r;
  logic [sdd_pkg::STATUS_W-1:0]   out_status_r;
  logic [SW-1:0]                  out_slot_r;

  logic [sdd_pkg::HASH_W-1:0] fold_sum;
  logic                       fold_hi;
  logic [SW:0]    fold_lo, p_sum, inc_sum;
  logic           idx_last;
  logic           st_we, len_we, chr_we;
  logic [SW-1:0]  st_waddr;
  logic [1:0]     st_wdata;
  logic [CAW-1:0] chr_addr;
  logic           out_free;

  // Slot status memory: bit 0 occupied, bit 1 already reported.
  logic [1:0]                  stat_mem [TABLE_SLOTS];
  logic [LW-1:0]               len_mem  [TABLE_SLOTS];
  logic [sdd_pkg::CHAR_W-1:0]  chr_mem  [TABLE_SLOTS*MAX_NAME_CHARS];
  logic [1:0]                  stat_q;
  logic [LW-1:0]               len_q;
  logic [sdd_pkg::CHAR_W-1:0]  chr_q;

  assign fold_sum = {{SW{1'b0}}, fold_r[sdd_pkg::HASH_W-1:SW]} * FOLD_K +
                    {{(sdd_pkg::HASH_W-SW){1'b0}}, fold_r[SW-1:0]};
  assign fold_hi  = fold_r[sdd_pkg::HASH_W-1:SW] != '0;
  assign fold_lo  = {1'b0, fold_r[SW-1:0]};
  assign p_sum    = {1'b0, p_r} + {1'b0, inc_r};
  assign inc_sum  = {1'b0, inc_r} + (SW+1)'(2);
  assign idx_last = (idx_r + LW'(1)) == job_len;
  assign chr_addr = base_r + CAW'(idx_r);
  assign buf_rd_addr = idx_r[NW-1:0];
  assign out_free = !out_valid_r || out_tready;
  assign clr_busy = state_r == S_CLR;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    fold_nxt     = fold_r;
    p_nxt        = p_r;
    inc_nxt      = inc_r;
    step_nxt     = step_r;
    base_nxt     = base_r;
    idx_nxt      = idx_r;
    res_st_nxt   = res_st_r;
    res_slot_nxt = res_slot_r;
    st_we        = 1'b0;
    st_waddr     = p_r;
    st_wdata     = 2'b00;
    len_we       = 1'b0;
    chr_we       = 1'b0;
    job_done     = 1'b0;
    case (state_r)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        clr_nxt  = clr_r + SW'(1);
        if (clr_r == SW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job.valid) begin
          if (job.overflow) begin
            res_st_nxt   = sdd_pkg::ST_LONG;
            res_slot_nxt = '0;
            state_nxt    = S_OUT;
          end else begin
            fold_nxt  = job.hash;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        // Fold the upper bits back onto the low SW bits until they are clear,
        // then one conditional subtract gives the home slot.
        if (fold_hi) begin
          fold_nxt = fold_sum;
        end else begin
          p_nxt     = (fold_lo >= NMOD) ? SW'(fold_lo - NMOD) : fold_r[SW-1:0];
          inc_nxt   = SW'(1);
          step_nxt  = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        base_nxt  = CAW'(p_r) * CAW'(MAX_NAME_CHARS);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        idx_nxt = '0;
        if (!stat_q[0]) begin
          st_we     = 1'b1;
          st_wdata  = 2'b01;
          len_we    = 1'b1;
          state_nxt = S_CPA;
        end else if (len_q == job_len) begin
          state_nxt = S_CMPA;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_CPA: begin
        state_nxt = S_CPB;
      end
      S_CPB: begin
        chr_we = 1'b1;
        if (idx_last) begin
          res_st_nxt   = sdd_pkg::ST_NEW;
          res_slot_nxt = p_r;
          state_nxt    = S_OUT;
        end else begin
          idx_nxt   = idx_r + LW'(1);
          state_nxt = S_CPA;
        end
      end
      S_CMPA: begin
        state_nxt = S_CMPB;
      end
      S_CMPB: begin
        if (chr_q != buf_rd_data) begin
          state_nxt = S_NEXT;
        end else if (idx_last) begin
          res_slot_nxt = p_r;
          if (stat_q[1]) begin
            res_st_nxt = sdd_pkg::ST_REPEAT;
          end else begin
            res_st_nxt = sdd_pkg::ST_SECOND;
            st_we      = 1'b1;
            st_wdata   = 2'b11;
          end
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + LW'(1);
          state_nxt = S_CMPA;
        end
      end
      S_NEXT: begin
        if (step_r == probe_limit) begin
          res_st_nxt   = sdd_pkg::ST_FULL;
          res_slot_nxt = '0;
          state_nxt    = S_OUT;
        end else begin
          step_nxt = step_r + sdd_pkg::LIMIT_W'(1);
          p_nxt    = (p_sum >= NMOD) ? SW'(p_sum - NMOD) : p_sum[SW-1:0];
          inc_nxt  = (inc_sum >= NMOD) ? SW'(inc_sum - NMOD) : inc_sum[SW-1:0];
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          job_done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (job_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fold_r     <= fold_nxt;
    p_r        <= p_nxt;
    inc_r      <= inc_nxt;
    step_r     <= step_nxt;
    base_r     <= base_nxt;
    idx_r      <= idx_nxt;
    res_st_r   <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    if (job_done) begin
      out_status_r <= res_st_r;
      out_slot_r   <= res_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stat_mem[st_waddr] <= st_wdata;
    end
    if (state_r == S_RD) begin
      stat_q <= stat_mem[p_r];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[p_r] <= job_len;
    end
    len_q <= len_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (chr_we) begin
      chr_mem[chr_addr] <= buf_rd_data;
    end
    chr_q <= chr_mem[chr_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= sdd_pkg::ST_LONG))
    else $error("result status out of range");

  a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !job_done && !out_valid_r)
    else $error("result produced during clearing pass");

  a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (p_r < SW'(TABLE_SLOTS)))
    else $error("probe slot outside table");

  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    job_done |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result not presented");

endmodule
`default_nettype wire

// File: sv/string_duplicate_detector.sv
// Top level of the string duplicate detector: probe limit register and the two halves.
// Depends on sdd_pkg, sdd_front and sdd_back.
//
// Usage: names arrive on the in_ stream one character per transfer, in_tdata
// holding the character and in_tlast marking the final character of a name.
// Characters are taken one per cycle while in_tready is high. After the last
// character the back end picks up the name, reduces the 32-bit hash modulo
// TABLE_SLOTS by folding, then probes with odd steps; each probe reads the
// slot status and stored length, then stores the name or, if the lengths match,
// compares it one character at a time; the verdict is registered before it is offered.
// One out_ transfer is made per name: out_tuser gives the status, out_tdata the slot.
// The front end holds a completed name until the back end has placed its
// result in the output register, so in_tready stays low meanwhile; the next
// name can then stream in while the result waits for out_tready. A stalled
// receiver holds the result and, once the next name completes, the engine.
// After reset the slot status memory is swept, one slot per cycle, with
// in_tready low; cfg_ writes are taken at any time and reset sets the
// probe limit to 2047.
`default_nettype none
module string_duplicate_detector #(
  parameter int TABLE_SLOTS    = 4093,
  parameter int MAX_NAME_CHARS = 40
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [7:0]                           in_tdata,   // [7:0] char_code
  input  wire                                  in_tlast,   // last_char
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [(($clog2(TABLE_SLOTS)+7)/8)*8-1:0] out_tdata, // slot_index, zero padded
  output logic [2:0]                           out_tuser,  // [2:0] status
  input  wire                                  cfg_wr_en,
  input  wire  [11:0]                          cfg_wr_data // probe_limit
);

  localparam int SW  = $clog2(TABLE_SLOTS);
  localparam int LW  = $clog2(MAX_NAME_CHARS + 1);
  localparam int NW  = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;
  localparam int CAW = $clog2(TABLE_SLOTS * MAX_NAME_CHARS);
  localparam int DW  = ((SW + 7) / 8) * 8;

  logic [sdd_pkg::LIMIT_W-1:0]  limit_r;
  sdd_pkg::job_ctl_t            job;
  logic [LW-1:0]                job_len;
  logic [NW-1:0]                buf_rd_addr;
  logic [sdd_pkg::CHAR_W-1:0]   buf_rd_data;
  logic                         job_done;
  logic                         clr_busy;
  logic [SW-1:0]                out_slot;

  // Probe limit: the number of odd steps tried after the home slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sdd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  sdd_front #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS),
    .LW(LW),
    .NW(NW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .clr_busy(clr_busy),
    .job_done(job_done),
    .job(job),
    .job_len(job_len),
    .buf_rd_addr(buf_rd_addr),
    .buf_rd_data(buf_rd_data)
  );

  sdd_back #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .MAX_NAME_CHARS(MAX_NAME_CHARS),
    .SW(SW),
    .LW(LW),
    .NW(NW),
    .CAW(CAW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .job(job),
    .job_len(job_len),
    .probe_limit(limit_r),
    .buf_rd_addr(buf_rd_addr),
    .buf_rd_data(buf_rd_data),
    .job_done(job_done),
    .clr_busy(clr_busy),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_status(out_tuser),
    .out_slot(out_slot)
  );

  // The slot index sits in the low bits of the data word.
  assign out_tdata = DW'(out_slot);

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for string_duplicate_detector: streams names, predicts each verdict.
// Depends on sdd_pkg and the string_duplicate_detector RTL only.
`timescale 1ns / 1ps
module testbench;

  localparam int SLOTS     = 4093;
  localparam int NAME_MAX  = 40;
  localparam int POOL_SIZE = 128;
  // Worst single name: every probe of a full sequence comparing forty characters.
  localparam int IDLE_LIMIT = 2000000;

  typedef struct {
    logic [sdd_pkg::STATUS_W-1:0] status;
    logic [15:0]                  slot;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_code
  logic        in_tlast = 1'b0; // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [11:0] slot_index, upper bits zero
  logic [2:0]  out_tuser;       // [2:0] status
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0; // probe_limit

  string_duplicate_detector i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the hash set, kept by the predictor.
  bit          slot_used [SLOTS];
  bit          slot_seen_twice [SLOTS];
  logic [5:0]  slot_len [SLOTS];
  logic [7:0]  slot_text [SLOTS][NAME_MAX];
  logic [7:0]  name_text [NAME_MAX];
  int          name_len = 0;
  logic [31:0] name_hash = '0;
  bit          name_too_long = 1'b0;
  logic [11:0] probe_limit = sdd_pkg::LIMIT_RESET;

  verdict_t    pending_verdicts [$];
  int          error_count = 0;

  // Names offered to the block; later names are often drawn from here again.
  logic [7:0]  name_buf [64];
  logic [7:0]  pool_text [POOL_SIZE][64];
  int          pool_len [POOL_SIZE];
  int          pool_count = 0;
  int          burst_left = 0;

  // Advance the shadow hash set by one accepted character and, at the end of
  // a name, queue the verdict the block must give.
  task automatic track_name_char(input logic [7:0] c, input logic last);
    verdict_t    v;
    logic [31:0] p;
    bit          same;
    name_hash = (name_hash << 5) + 32'(c);
    if (name_len < NAME_MAX) begin
      name_text[name_len] = c;
      name_len++;
    end else begin
      name_too_long = 1'b1;
    end
    if (!last) return;
    v.status = sdd_pkg::ST_FULL;
    v.slot   = '0;
    if (name_too_long) begin
      v.status = sdd_pkg::ST_LONG;
    end else begin
      p = name_hash % SLOTS;
      for (int step = 0; step <= int'(probe_limit); step++) begin
        if (step > 0) p = (p + 2 * step - 1) % SLOTS;
        if (!slot_used[p]) begin
          slot_used[p] = 1'b1;
          slot_seen_twice[p] = 1'b0;
          slot_len[p] = 6'(name_len);
          for (int i = 0; i < name_len; i++) slot_text[p][i] = name_text[i];
          v.status = sdd_pkg::ST_NEW;
          v.slot = 16'(p);
          break;
        end
        same = (int'(slot_len[p]) == name_len);
        for (int i = 0; same && i < name_len; i++) same = (slot_text[p][i] == name_text[i]);
        if (same) begin
          v.status = slot_seen_twice[p] ? sdd_pkg::ST_REPEAT : sdd_pkg::ST_SECOND;
          slot_seen_twice[p] = 1'b1;
          v.slot = 16'(p);
          break;
        end
      end
    end
    pending_verdicts.push_back(v);
    name_len = 0;
    name_hash = '0;
    name_too_long = 1'b0;
  endtask

  // Offer one character; the sender runs in bursts with random gaps between them.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    track_name_char(c, last);
    burst_left--;
  endtask

  task automatic send_name(input int len);
    for (int i = 0; i < len; i++) send_char(name_buf[i], i == len - 1);
  endtask

  task automatic send_two(input logic [7:0] a, input logic [7:0] b);
    name_buf[0] = a;
    name_buf[1] = b;
    send_name(2);
  endtask

  task automatic send_three(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    name_buf[0] = a;
    name_buf[1] = b;
    name_buf[2] = c;
    send_name(3);
  endtask

  // Let every verdict come back and the engine settle before touching the register.
  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_probe_limit(input logic [11:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    probe_limit = value;
  endtask

  // Extremes of the character and length fields, duplicates and overlong names.
  task automatic test_names_directed;
    name_buf[0] = 8'h01; send_name(1);
    name_buf[0] = 8'hFF; send_name(1);
    name_buf[0] = 8'h00; send_name(1);
    name_buf[0] = 8'h01; send_name(1);
    name_buf[0] = 8'h01; send_name(1);
    for (int i = 0; i < NAME_MAX; i++) name_buf[i] = 8'hFF;
    send_name(NAME_MAX);
    send_name(NAME_MAX);
    for (int i = 0; i < NAME_MAX + 1; i++) name_buf[i] = 8'(i * 37 + 1);
    send_name(NAME_MAX + 1);
    // An overlong name leaves no trace, so its first forty characters are new.
    send_name(NAME_MAX);
  endtask

  // Names whose hashes collide on shared home slots, tried under several probe limits.
  task automatic test_collisions;
    send_two(8'd0, 8'd5);
    send_two(8'd128, 8'd2);
    send_two(8'd255, 8'd31);
    set_probe_limit(12'd0);
    send_three(8'd11, 8'd31, 8'd23);   // home slot taken by another name: table full
    send_two(8'd0, 8'd5);              // found at home with no probing
    set_probe_limit(12'd1);
    send_three(8'd15, 8'd31, 8'd20);
    send_two(8'd128, 8'd2);
    set_probe_limit(12'd2);
    send_three(8'd15, 8'd31, 8'd20);
  endtask

  // Mostly well-formed names, many of them repeats, under one probe limit.
  task automatic test_random_names(input int char_budget);
    int sent;
    int len;
    int pick;
    int kind;
    sent = 0;
    while (sent < char_budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 40 && pool_count > 0) begin
        pick = $urandom_range(0, pool_count - 1);
        len = pool_len[pick];
        for (int i = 0; i < len; i++) name_buf[i] = pool_text[pick][i];
      end else begin
        if (kind < 85)      len = $urandom_range(1, 8);
        else if (kind < 92) len = NAME_MAX;
        else if (kind < 96) len = $urandom_range(NAME_MAX + 1, 50);
        else                len = $urandom_range(9, NAME_MAX);
        for (int i = 0; i < len; i++) name_buf[i] = 8'($urandom_range(0, 255));
        if (pool_count < POOL_SIZE) begin
          pick = pool_count;
          pool_count++;
        end else begin
          pick = $urandom_range(0, POOL_SIZE - 1);
        end
        pool_len[pick] = len;
        for (int i = 0; i < len; i++) pool_text[pick][i] = name_buf[i];
      end
      send_name(len);
      sent += len;
    end
  endtask

  task automatic test_limit_sweep;
    test_random_names(275);
    set_probe_limit(12'd4095);
    test_random_names(275);
    set_probe_limit(12'd1);
    test_random_names(225);
    set_probe_limit(12'd4093);
    test_random_names(225);
    set_probe_limit(12'($urandom_range(2, 4092)));
    test_random_names(200);
    set_probe_limit(12'd0);
    test_random_names(200);
  endtask

  // Receiver stalls on a pattern redrawn at random from four modes.
  int       stall_mode = 0;
  int       stall_cycle = 0;
  int       idle_cycles = 0;
  verdict_t want;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_tready <= (stall_cycle % 16) < 12;
      end
    endcase
  end

  // Check every result transfer against the oldest predicted verdict, and
  // end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with no verdict pending: status %0d slot %0d",
               out_tuser, out_tdata);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_tdata);
          error_count++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_names_directed();
    test_collisions();
    set_probe_limit(sdd_pkg::LIMIT_RESET);
    test_limit_sweep();
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sdd_pkg.sv
sv/sdd_front.sv
sv/sdd_back.sv
sv/string_duplicate_detector.sv
tb/sv/testbench.sv
